FILE: hdl/da_pkg.sv
// Package for the dihedral angle pipeline: widths, payload types, the
// normalizing helpers and the CORDIC arctangent table.
// No dependencies.
package da_pkg;

  localparam int COORD_BITS = 24;

  // Plane normals, exact.
  localparam int NRM_W = 2 * COORD_BITS + 1;
  localparam int MAG_W = NRM_W - 1;

  // Sign term a . n2 is built from two partial products per component.
  localparam int SPLIT = (NRM_W + 1) / 2;
  localparam int HI_W  = NRM_W - SPLIT;
  localparam int PH_W  = COORD_BITS + HI_W + 2;
  localparam int PL_W  = COORD_BITS + SPLIT + 3;
  localparam int T_W   = COORD_BITS + NRM_W + 3;

  // Scaled vectors keep their largest magnitude in [2^29, 2^30).
  localparam int NORM_TOP = 30;
  localparam int M_W      = NORM_TOP + 1;
  localparam int G_W      = 2 * M_W + 1;
  localparam int GM_W     = G_W - 1;
  localparam int WIDE_W   = (MAG_W > GM_W) ? MAG_W : GM_W;
  localparam int WPOS_W   = $clog2(WIDE_W);

  // Integer square root.
  localparam int SQ_W      = 2 * NORM_TOP + 2;
  localparam int RT_W      = SQ_W / 2;
  localparam int SQ_PER    = 4;
  localparam int SQ_STAGES = (RT_W + SQ_PER - 1) / SQ_PER;

  // CORDIC vectoring.
  localparam int CX_W         = NORM_TOP + 4;
  localparam int CZ_W         = 28;
  localparam int DEG_FRAC     = 16;
  localparam int OUT_FRAC     = 7;
  localparam int ANGLE_W      = 16;
  localparam int CORDIC_STEPS = 20;
  localparam int CR_PER       = 4;
  localparam int CR_STAGES    = (CORDIC_STEPS + CR_PER - 1) / CR_PER;

  localparam logic signed [CZ_W-1:0] Z_90 = CZ_W'(90 * (2 ** DEG_FRAC));
  localparam logic signed [CZ_W-1:0] Z_180 = CZ_W'(180 * (2 ** DEG_FRAC));
  localparam logic signed [CZ_W-1:0] ROUND_HALF = CZ_W'(2 ** (DEG_FRAC - OUT_FRAC - 1));
  localparam logic signed [ANGLE_W-1:0] ANGLE_DEGEN = ANGLE_W'(-90 * (2 ** OUT_FRAC));

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [M_W-1:0] mv_t;

  typedef struct packed {
    coord_t a_x;
    coord_t a_y;
    coord_t a_z;
    coord_t b_x;
    coord_t b_y;
    coord_t b_z;
    coord_t c_x;
    coord_t c_y;
    coord_t c_z;
  } da_in_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic                      degenerate;
  } da_out_t;

  typedef struct packed {
    logic positive;
    logic degen;
  } da_flags_t;

  typedef struct packed {
    mv_t       m1_x;
    mv_t       m1_y;
    mv_t       m1_z;
    mv_t       m2_x;
    mv_t       m2_y;
    mv_t       m2_z;
    da_flags_t flags;
  } da_norm_t;

  typedef struct packed {
    logic [SQ_W-1:0] rad;
    mv_t             d;
    da_flags_t       flags;
  } da_sq_t;

  typedef struct packed {
    logic [RT_W-1:0] s;
    mv_t             d;
    da_flags_t       flags;
  } da_cr_t;

  // Position of the highest set bit; zero for a zero word.
  function automatic logic [WPOS_W-1:0] lead_pos(logic [WIDE_W-1:0] v);
    logic [WPOS_W-1:0] p;
    p = '0;
    for (int i = 0; i < WIDE_W; i++) begin
      if (v[i]) p = WPOS_W'(i);
    end
    return p;
  endfunction

  // Scales a magnitude by the shift that brings a group leader at bit p to
  // bit NORM_TOP-1. Right shifts truncate.
  function automatic logic [NORM_TOP-1:0] norm_shift(logic [WIDE_W-1:0] m,
                                                     logic [WPOS_W-1:0] p);
    logic [WIDE_W-1:0] r;
    if (p >= WPOS_W'(NORM_TOP)) begin
      r = m >> (p - WPOS_W'(NORM_TOP - 1));
    end else begin
      r = m << (WPOS_W'(NORM_TOP - 1) - p);
    end
    return r[NORM_TOP-1:0];
  endfunction

  // Arctangent of 2^-i in units of 2^-16 degree, rounded to nearest.
  function automatic logic signed [CZ_W-1:0] atan_step(int i);
    int t;
    case (i)
      0:       t = 2949120;
      1:       t = 1740967;
      2:       t = 919879;
      3:       t = 466945;
      4:       t = 234379;
      5:       t = 117304;
      6:       t = 58666;
      7:       t = 29335;
      8:       t = 14668;
      9:       t = 7334;
      10:      t = 3667;
      11:      t = 1833;
      12:      t = 917;
      13:      t = 458;
      14:      t = 229;
      15:      t = 115;
      16:      t = 57;
      17:      t = 29;
      18:      t = 14;
      19:      t = 7;
      default: t = 0;
    endcase
    return CZ_W'(t);
  endfunction

endpackage

FILE: hdl/da_ifs.sv
// Stream interfaces for the dihedral angle block: input vectors and results.
// Depends on da_pkg.
interface da_in_if import da_pkg::*; ;
  logic   valid;
  logic   ready;
  da_in_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface da_out_if import da_pkg::*; ;
  logic    valid;
  logic    ready;
  da_out_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: hdl/da_front.sv
// Front pipeline: plane normals, exact sign of a . n2, degenerate test and
// scaling of both normals. Five register stages. Depends on da_pkg.
module da_front import da_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  da_in_t   in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output da_norm_t out_data
);

  localparam int STAGES = 5;
  localparam int P_W    = 2 * COORD_BITS;
  localparam int HP_W   = COORD_BITS + HI_W;
  localparam int LP_W   = COORD_BITS + SPLIT + 1;

  logic [STAGES-1:0] v;
  logic [STAGES-1:0] en;

  always_comb begin
    en[STAGES-1] = !v[STAGES-1] || out_ready;
    for (int s = STAGES - 2; s >= 0; s--) en[s] = !v[s] || en[s+1];
  end

  assign in_ready  = en[0];
  assign out_valid = v[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int s = 1; s < STAGES; s++) begin
        if (en[s]) v[s] <= v[s-1];
      end
    end
  end

  coord_t a [3];
  coord_t b [3];
  coord_t c [3];

  assign a[0] = in_data.a_x;
  assign a[1] = in_data.a_y;
  assign a[2] = in_data.a_z;
  assign b[0] = in_data.b_x;
  assign b[1] = in_data.b_y;
  assign b[2] = in_data.b_z;
  assign c[0] = in_data.c_x;
  assign c[1] = in_data.c_y;
  assign c[2] = in_data.c_z;

  // Stage 1: the twelve cross-product terms.
  logic signed [P_W-1:0] s1_p [12];
  coord_t                s1_a [3];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        s1_p[2*i]     <= P_W'(a[(i+1)%3]) * P_W'(b[(i+2)%3]);
        s1_p[2*i+1]   <= P_W'(a[(i+2)%3]) * P_W'(b[(i+1)%3]);
        s1_p[6+2*i]   <= P_W'(c[(i+1)%3]) * P_W'(b[(i+2)%3]);
        s1_p[6+2*i+1] <= P_W'(c[(i+2)%3]) * P_W'(b[(i+1)%3]);
        s1_a[i]       <= a[i];
      end
    end
  end

  // Stage 2: normals n1 (entries 0..2) and n2 (entries 3..5).
  logic signed [NRM_W-1:0] s2_n [6];
  coord_t                  s2_a [3];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int j = 0; j < 6; j++) begin
        s2_n[j] <= NRM_W'(s1_p[2*j]) - NRM_W'(s1_p[2*j+1]);
      end
      s2_a <= s1_a;
    end
  end

  // Stage 3: magnitudes, degenerate test, sign-term partial products.
  logic [MAG_W-1:0]        nmag [6];
  logic signed [HI_W-1:0]  n2_hi [3];
  logic signed [SPLIT:0]   n2_lo [3];

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      nmag[j] = s2_n[j][NRM_W-1] ? MAG_W'(-s2_n[j]) : MAG_W'(s2_n[j]);
    end
    for (int i = 0; i < 3; i++) begin
      n2_hi[i] = $signed(s2_n[3+i][NRM_W-1:SPLIT]);
      n2_lo[i] = $signed({1'b0, s2_n[3+i][SPLIT-1:0]});
    end
  end

  logic [MAG_W-1:0]        s3_mag [6];
  logic                    s3_neg [6];
  logic [MAG_W-1:0]        s3_or  [2];
  logic                    s3_degen;
  logic signed [HP_W-1:0]  s3_phi [3];
  logic signed [LP_W-1:0]  s3_plo [3];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int j = 0; j < 6; j++) begin
        s3_mag[j] <= nmag[j];
        s3_neg[j] <= s2_n[j][NRM_W-1];
      end
      for (int i = 0; i < 3; i++) begin
        s3_phi[i] <= HP_W'(s2_a[i]) * HP_W'(n2_hi[i]);
        s3_plo[i] <= LP_W'(s2_a[i]) * LP_W'(n2_lo[i]);
      end
      s3_or[0] <= nmag[0] | nmag[1] | nmag[2];
      s3_or[1] <= nmag[3] | nmag[4] | nmag[5];
      s3_degen <= (s2_n[0] == '0 && s2_n[1] == '0 && s2_n[2] == '0) ||
                  (s2_n[3] == '0 && s2_n[4] == '0 && s2_n[5] == '0);
    end
  end

  // Stage 4: partial sums and leading-one positions.
  logic signed [PH_W-1:0] s4_sh;
  logic signed [PL_W-1:0] s4_sl;
  logic [WPOS_W-1:0]      s4_pos [2];
  logic [MAG_W-1:0]       s4_mag [6];
  logic                   s4_neg [6];
  logic                   s4_degen;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_sh    <= PH_W'(s3_phi[0]) + PH_W'(s3_phi[1]) + PH_W'(s3_phi[2]);
      s4_sl    <= PL_W'(s3_plo[0]) + PL_W'(s3_plo[1]) + PL_W'(s3_plo[2]);
      s4_pos[0] <= lead_pos(WIDE_W'(s3_or[0]));
      s4_pos[1] <= lead_pos(WIDE_W'(s3_or[1]));
      s4_mag   <= s3_mag;
      s4_neg   <= s3_neg;
      s4_degen <= s3_degen;
    end
  end

  // Stage 5: sign of a . n2 and the scaled normals.
  logic signed [T_W-1:0] total;
  mv_t                   mv [6];

  always_comb begin
    total = (T_W'(s4_sh) <<< SPLIT) + T_W'(s4_sl);
    for (int k = 0; k < 2; k++) begin
      for (int i = 0; i < 3; i++) begin
        mv[3*k+i] = $signed({1'b0, norm_shift(WIDE_W'(s4_mag[3*k+i]), s4_pos[k])});
        if (s4_neg[3*k+i]) mv[3*k+i] = -mv[3*k+i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      out_data.m1_x           <= mv[0];
      out_data.m1_y           <= mv[1];
      out_data.m1_z           <= mv[2];
      out_data.m2_x           <= mv[3];
      out_data.m2_y           <= mv[4];
      out_data.m2_z           <= mv[5];
      // The sign term is -|b|^2 (a . n2), so it is positive when a . n2 < 0.
      out_data.flags.positive <= total[T_W-1];
      out_data.flags.degen    <= s4_degen;
    end
  end

endmodule

FILE: hdl/da_prep.sv
// Middle pipeline: dot and cross product of the scaled normals, joint
// scaling of the four values and the sum of squares of the cross product.
// Seven register stages. Depends on da_pkg.
module da_prep import da_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  da_norm_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output da_sq_t   out_data
);

  localparam int STAGES = 7;
  localparam int PM_W   = 2 * M_W;
  localparam int SQP_W  = 2 * NORM_TOP;

  logic [STAGES-1:0] v;
  logic [STAGES-1:0] en;

  always_comb begin
    en[STAGES-1] = !v[STAGES-1] || out_ready;
    for (int s = STAGES - 2; s >= 0; s--) en[s] = !v[s] || en[s+1];
  end

  assign in_ready  = en[0];
  assign out_valid = v[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int s = 1; s < STAGES; s++) begin
        if (en[s]) v[s] <= v[s-1];
      end
    end
  end

  mv_t m1 [3];
  mv_t m2 [3];

  assign m1[0] = in_data.m1_x;
  assign m1[1] = in_data.m1_y;
  assign m1[2] = in_data.m1_z;
  assign m2[0] = in_data.m2_x;
  assign m2[1] = in_data.m2_y;
  assign m2[2] = in_data.m2_z;

  // Stage 1: three dot terms and six cross terms.
  logic signed [PM_W-1:0] s1_p [9];
  da_flags_t              s1_fl;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        s1_p[i]       <= PM_W'($signed(m1[i])) * PM_W'($signed(m2[i]));
        s1_p[3+2*i]   <= PM_W'($signed(m1[(i+1)%3])) * PM_W'($signed(m2[(i+2)%3]));
        s1_p[3+2*i+1] <= PM_W'($signed(m1[(i+2)%3])) * PM_W'($signed(m2[(i+1)%3]));
      end
      s1_fl <= in_data.flags;
    end
  end

  // Stage 2: g[0] = m1 . m2, g[1..3] = m1 x m2.
  logic signed [G_W-1:0] s2_g [4];
  da_flags_t             s2_fl;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_g[0] <= G_W'(s1_p[0]) + G_W'(s1_p[1]) + G_W'(s1_p[2]);
      for (int i = 0; i < 3; i++) begin
        s2_g[1+i] <= G_W'(s1_p[3+2*i]) - G_W'(s1_p[3+2*i+1]);
      end
      s2_fl <= s1_fl;
    end
  end

  // Stage 3: magnitudes and their combined bit pattern.
  logic [GM_W-1:0] gmag [4];
  logic [GM_W-1:0] s3_mag [4];
  logic            s3_neg0;
  logic [GM_W-1:0] s3_or;
  da_flags_t       s3_fl;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      gmag[j] = s2_g[j][G_W-1] ? GM_W'(-s2_g[j]) : GM_W'(s2_g[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_mag  <= gmag;
      s3_neg0 <= s2_g[0][G_W-1];
      s3_or   <= gmag[0] | gmag[1] | gmag[2] | gmag[3];
      s3_fl   <= s2_fl;
    end
  end

  // Stage 4: leading-one position of the group.
  logic [WPOS_W-1:0] s4_pos;
  logic [GM_W-1:0]   s4_mag [4];
  logic              s4_neg0;
  da_flags_t         s4_fl;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_pos  <= lead_pos(WIDE_W'(s3_or));
      s4_mag  <= s3_mag;
      s4_neg0 <= s3_neg0;
      s4_fl   <= s3_fl;
    end
  end

  // Stage 5: scaled d (signed) and scaled cross magnitudes.
  mv_t                 d_scaled;
  logic [NORM_TOP-1:0] s5_w [3];
  mv_t                 s5_d;
  da_flags_t           s5_fl;

  always_comb begin
    d_scaled = $signed({1'b0, norm_shift(WIDE_W'(s4_mag[0]), s4_pos)});
    if (s4_neg0) d_scaled = -d_scaled;
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int i = 0; i < 3; i++) begin
        s5_w[i] <= norm_shift(WIDE_W'(s4_mag[1+i]), s4_pos);
      end
      s5_d  <= d_scaled;
      s5_fl <= s4_fl;
    end
  end

  // Stage 6: squares.
  logic [SQP_W-1:0] s6_sq [3];
  mv_t              s6_d;
  da_flags_t        s6_fl;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int i = 0; i < 3; i++) begin
        s6_sq[i] <= SQP_W'(s5_w[i]) * SQP_W'(s5_w[i]);
      end
      s6_d  <= s5_d;
      s6_fl <= s5_fl;
    end
  end

  // Stage 7: sum of squares.
  always_ff @(posedge clk) begin
    if (en[6]) begin
      out_data.rad   <= SQ_W'(s6_sq[0]) + SQ_W'(s6_sq[1]) + SQ_W'(s6_sq[2]);
      out_data.d     <= s6_d;
      out_data.flags <= s6_fl;
    end
  end

endmodule

FILE: hdl/da_sqrt.sv
// Pipelined integer square root, restoring, one result bit per step and
// SQ_PER steps per register stage. Depends on da_pkg.
module da_sqrt import da_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  da_sq_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output da_cr_t out_data
);

  typedef struct packed {
    logic [SQ_W-1:0] xr;
    logic [RT_W+1:0] rem;
    logic [RT_W-1:0] root;
  } sq_st_t;

  function automatic sq_st_t sq_iter(sq_st_t t);
    sq_st_t          r;
    logic [RT_W+1:0] cur;
    logic [RT_W+1:0] trial;
    cur   = {t.rem[RT_W-1:0], t.xr[SQ_W-1 -: 2]};
    trial = {t.root, 2'b01};
    r.xr  = t.xr << 2;
    if (cur >= trial) begin
      r.rem  = cur - trial;
      r.root = {t.root[RT_W-2:0], 1'b1};
    end else begin
      r.rem  = cur;
      r.root = {t.root[RT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  logic [SQ_STAGES-1:0] v;
  logic [SQ_STAGES-1:0] en;

  always_comb begin
    en[SQ_STAGES-1] = !v[SQ_STAGES-1] || out_ready;
    for (int s = SQ_STAGES - 2; s >= 0; s--) en[s] = !v[s] || en[s+1];
  end

  assign in_ready  = en[0];
  assign out_valid = v[SQ_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int s = 1; s < SQ_STAGES; s++) begin
        if (en[s]) v[s] <= v[s-1];
      end
    end
  end

  sq_st_t    st  [SQ_STAGES];
  sq_st_t    nxt [SQ_STAGES];
  mv_t       d   [SQ_STAGES];
  da_flags_t fl  [SQ_STAGES];

  always_comb begin
    sq_st_t t;
    for (int s = 0; s < SQ_STAGES; s++) begin
      if (s == 0) begin
        t.xr   = in_data.rad;
        t.rem  = '0;
        t.root = '0;
      end else begin
        t = st[s-1];
      end
      for (int k = 0; k < SQ_PER; k++) begin
        if (s * SQ_PER + k < RT_W) t = sq_iter(t);
      end
      nxt[s] = t;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < SQ_STAGES; s++) begin
      if (en[s]) begin
        st[s] <= nxt[s];
        d[s]  <= (s == 0) ? in_data.d : d[s-1];
        fl[s] <= (s == 0) ? in_data.flags : fl[s-1];
      end
    end
  end

  assign out_data.s     = st[SQ_STAGES-1].root;
  assign out_data.d     = d[SQ_STAGES-1];
  assign out_data.flags = fl[SQ_STAGES-1];

endmodule

FILE: hdl/da_cordic.sv
// CORDIC vectoring for atan2(s, d) in degrees, then clamping, rounding to
// Q8.7 and the sign and degenerate handling. Depends on da_pkg.
module da_cordic import da_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  da_cr_t  in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output da_out_t out_data
);

  localparam int STAGES = CR_STAGES + 2;

  typedef struct packed {
    logic signed [CX_W-1:0] x;
    logic signed [CX_W-1:0] y;
    logic signed [CZ_W-1:0] z;
  } cr_st_t;

  // Arithmetic shift whose result is truncated toward zero.
  function automatic logic signed [CX_W-1:0] shr_tz(logic signed [CX_W-1:0] val, int k);
    logic signed [CX_W-1:0] bias;
    bias = $signed(CX_W'((64'd1 << k) - 64'd1));
    if (val[CX_W-1]) return (val + bias) >>> k;
    return val >>> k;
  endfunction

  function automatic cr_st_t cr_step(cr_st_t t, int i);
    cr_st_t                 r;
    logic signed [CX_W-1:0] dx;
    logic signed [CX_W-1:0] dy;
    dx = shr_tz(t.y, i);
    dy = shr_tz(t.x, i);
    if (!t.y[CX_W-1]) begin
      r.x = t.x + dx;
      r.y = t.y - dy;
      r.z = t.z + atan_step(i);
    end else begin
      r.x = t.x - dx;
      r.y = t.y + dy;
      r.z = t.z - atan_step(i);
    end
    return r;
  endfunction

  logic [STAGES-1:0] v;
  logic [STAGES-1:0] en;

  always_comb begin
    en[STAGES-1] = !v[STAGES-1] || out_ready;
    for (int s = STAGES - 2; s >= 0; s--) en[s] = !v[s] || en[s+1];
  end

  assign in_ready  = en[0];
  assign out_valid = v[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int s = 1; s < STAGES; s++) begin
        if (en[s]) v[s] <= v[s-1];
      end
    end
  end

  cr_st_t    st  [CR_STAGES+1];
  cr_st_t    nxt [CR_STAGES+1];
  da_flags_t fl  [CR_STAGES+1];

  always_comb begin
    cr_st_t t;
    // A negative d starts from a quarter turn so the rotation converges.
    if (in_data.d[M_W-1]) begin
      nxt[0].x = $signed(CX_W'(in_data.s));
      nxt[0].y = -CX_W'($signed(in_data.d));
      nxt[0].z = Z_90;
    end else begin
      nxt[0].x = CX_W'($signed(in_data.d));
      nxt[0].y = $signed(CX_W'(in_data.s));
      nxt[0].z = '0;
    end
    for (int s = 1; s <= CR_STAGES; s++) begin
      t = st[s-1];
      for (int k = 0; k < CR_PER; k++) begin
        if ((s - 1) * CR_PER + k < CORDIC_STEPS) t = cr_step(t, (s - 1) * CR_PER + k);
      end
      nxt[s] = t;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s <= CR_STAGES; s++) begin
      if (en[s]) begin
        st[s] <= nxt[s];
        fl[s] <= (s == 0) ? in_data.flags : fl[s-1];
      end
    end
  end

  logic signed [CZ_W-1:0] zc;
  logic signed [CZ_W-1:0] rem_deg;
  logic signed [CZ_W-1:0] q;
  da_out_t                res;

  always_comb begin
    zc = st[CR_STAGES].z;
    if (zc[CZ_W-1]) zc = '0;
    else if (zc > Z_180) zc = Z_180;
    rem_deg = Z_180 - zc;
    q = (rem_deg + ROUND_HALF) >>> (DEG_FRAC - OUT_FRAC);
    if (!fl[CR_STAGES].positive) q = -q;
    if (fl[CR_STAGES].degen) begin
      res.angle      = ANGLE_DEGEN;
      res.degenerate = 1'b1;
    end else begin
      res.angle      = q[ANGLE_W-1:0];
      res.degenerate = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[STAGES-1]) out_data <= res;
  end

endmodule

FILE: hdl/dihedral_angle.sv
// Top level of the dihedral angle block: front, middle, square root and
// CORDIC pipelines in a row. Depends on da_pkg, da_ifs and the da_* modules.
//
// Takes one request of three Q13.10 vectors a, b, c every clock cycle unless
// back-pressure stalls it, and returns the signed torsion angle in Q8.7
// degrees with a degenerate flag, in order, one result per request. The
// square root yields 31 bits at four bits per stage and the CORDIC runs its
// 20 steps at four per stage. Every stage carries its own valid bit and
// holds under back-pressure, so a stalled result stops nothing that still
// has free stages ahead of it.
module dihedral_angle import da_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  da_in_if.sink    items,
  da_out_if.source results
);

  logic     fr_valid;
  logic     fr_ready;
  da_norm_t fr_data;
  logic     pr_valid;
  logic     pr_ready;
  da_sq_t   pr_data;
  logic     sq_valid;
  logic     sq_ready;
  da_cr_t   sq_data;

  da_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .in_data   (items.data),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_data  (fr_data)
  );

  da_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_data   (fr_data),
    .out_valid (pr_valid),
    .out_ready (pr_ready),
    .out_data  (pr_data)
  );

  da_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pr_valid),
    .in_ready  (pr_ready),
    .in_data   (pr_data),
    .out_valid (sq_valid),
    .out_ready (sq_ready),
    .out_data  (sq_data)
  );

  da_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .in_ready  (sq_ready),
    .in_data   (sq_data),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_data  (results.data)
  );

endmodule

FILE: dv/tb_dihedral_angle.sv
// Testbench for the dihedral angle block: drives request streams of vectors
// and checks every result against its own bit-exact predictor.
// Depends on da_pkg, da_ifs and the dihedral_angle RTL.
module tb_dihedral_angle import da_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint vec4_t [4];

  localparam int LATENCY = 5 + 7 + SQ_STAGES + CR_STAGES + 2;
  localparam int LIMIT = 300000;
  localparam int N_RANDOM = 1200;
  localparam int QUIET_TAIL = 150;
  localparam longint DEG1 = 64'd1 << DEG_FRAC;

  // Arctangent steps, units of 2^-16 degree.
  localparam longint ATAN_DEG [CORDIC_STEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};

  // Scales the first n entries so the largest magnitude sits in [2^29, 2^30).
  function automatic void scale_group(inout vec4_t v, input int n);
    longint unsigned mx, m;
    int r, l;
    mx = 0;
    r = 0;
    l = 0;
    for (int i = 0; i < n; i++) begin
      m = (v[i] < 0) ? -v[i] : v[i];
      if (m > mx) mx = m;
    end
    if (mx == 0) return;
    while ((mx >> r) >= (64'd1 << NORM_TOP)) r++;
    if (r == 0)
      while ((mx << l) < (64'd1 << (NORM_TOP - 1))) l++;
    for (int i = 0; i < n; i++) begin
      m = (v[i] < 0) ? -v[i] : v[i];
      m = (m >> r) << l;
      v[i] = (v[i] < 0) ? -longint'(m) : longint'(m);
    end
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt >>= 2;
    while (bt != 0) begin
      if (x >= res + bt) begin
        x -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  function automatic longint trunc_shift(longint v, int k);
    longint unsigned m;
    m = (v < 0) ? -v : v;
    m = m >> k;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic da_out_t torsion_of(da_in_t d);
    da_out_t o;
    longint a [3], b [3], c [3];
    vec4_t n1, n2, g;
    logic signed [127:0] acc, p, q;
    longint unsigned ss;
    longint x, y, z, t, dx, dy, r, qd;
    bit positive;
    a = '{d.a_x, d.a_y, d.a_z};
    b = '{d.b_x, d.b_y, d.b_z};
    c = '{d.c_x, d.c_y, d.c_z};
    n1 = '{a[1]*b[2] - a[2]*b[1], a[2]*b[0] - a[0]*b[2], a[0]*b[1] - a[1]*b[0], 0};
    n2 = '{c[1]*b[2] - c[2]*b[1], c[2]*b[0] - c[0]*b[2], c[0]*b[1] - c[1]*b[0], 0};
    if ((n1[0] == 0 && n1[1] == 0 && n1[2] == 0) ||
        (n2[0] == 0 && n2[1] == 0 && n2[2] == 0)) begin
      o.angle = ANGLE_DEGEN;
      o.degenerate = 1'b1;
      return o;
    end
    // The sign term is -|b|^2 (a . n2), so only the sign of a . n2 matters.
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      p = a[i];
      q = n2[i];
      acc += p * q;
    end
    positive = acc[127];
    scale_group(n1, 3);
    scale_group(n2, 3);
    g[0] = n1[0]*n2[0] + n1[1]*n2[1] + n1[2]*n2[2];
    g[1] = n1[1]*n2[2] - n1[2]*n2[1];
    g[2] = n1[2]*n2[0] - n1[0]*n2[2];
    g[3] = n1[0]*n2[1] - n1[1]*n2[0];
    scale_group(g, 4);
    ss = 0;
    for (int i = 1; i < 4; i++) ss += longint'(g[i] * g[i]);
    x = g[0];
    y = longint'(int_sqrt(ss));
    z = 0;
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      z = 90 * DEG1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = trunc_shift(y, i);
      dy = trunc_shift(x, i);
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += ATAN_DEG[i];
      end else begin
        x -= dx;
        y += dy;
        z -= ATAN_DEG[i];
      end
    end
    if (z < 0) z = 0;
    if (z > 180 * DEG1) z = 180 * DEG1;
    r = 180 * DEG1 - z;
    qd = (r + (64'd1 << (DEG_FRAC - OUT_FRAC - 1))) >>> (DEG_FRAC - OUT_FRAC);
    if (!positive) qd = -qd;
    o.angle = qd[ANGLE_W-1:0];
    o.degenerate = 1'b0;
    return o;
  endfunction

  class angle_board;
    da_out_t pending [$];
    int errors;
    int checked;
    int degen_seen;

    function void note(da_in_t d);
      pending.push_back(torsion_of(d));
    endfunction

    function void check(da_out_t got);
      da_out_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result angle=%0d degenerate=%0b",
                 $time, got.angle, got.degenerate);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.degenerate) degen_seen++;
      if (got.angle !== want.angle) begin
        $display("%0t: angle mismatch expected %0d actual %0d",
                 $time, want.angle, got.angle);
        errors++;
      end
      if (got.degenerate !== want.degenerate) begin
        $display("%0t: degenerate mismatch expected %0b actual %0b",
                 $time, want.degenerate, got.degenerate);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  da_in_if  items ();
  da_out_if results ();

  dihedral_angle uut (.clk(clk), .rst(rst), .items(items.sink), .results(results.source));

  angle_board board = new();
  bit quiet = 1'b0;
  int accepted = 0;
  longint cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
    if (!rst && items.valid && items.ready) begin
      board.note(items.data);
      accepted++;
    end
    if (!rst && results.valid && results.ready) board.check(results.data);
  end

  // Result side: random stall bursts, one long hold-off to fill the pipeline.
  initial begin
    int n;
    bit held;
    held = 1'b0;
    results.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held && accepted >= 300) begin
        held = 1'b1;
        results.ready = 1'b0;
        for (int i = 0; i < 200; i++) @(negedge clk);
      end
      if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 6);
        results.ready = 1'b0;
        repeat (n) @(negedge clk);
      end
      results.ready = 1'b1;
      n = $urandom_range(1, 12);
      repeat (n) @(negedge clk);
    end
  end

  task automatic send_item(da_in_t d);
    int n;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 6);
      items.valid = 1'b0;
      repeat (n) @(negedge clk);
    end
    items.valid = 1'b1;
    items.data = d;
    do @(posedge clk); while (!items.ready);
    @(negedge clk);
  endtask

  function automatic coord_t rand_coord(int bits);
    longint v;
    v = longint'($signed($urandom)) <<< 32;
    v = v >>> (64 - bits);
    return coord_t'(v);
  endfunction

  function automatic da_in_t vecs(longint ax, ay, az, bx, by, bz, cx, cy, cz);
    da_in_t d;
    d = '{coord_t'(ax), coord_t'(ay), coord_t'(az), coord_t'(bx), coord_t'(by),
          coord_t'(bz), coord_t'(cx), coord_t'(cy), coord_t'(cz)};
    return d;
  endfunction

  function automatic da_in_t random_item();
    da_in_t d;
    int bits, kind;
    longint k1, k2;
    bits = $urandom_range(1, COORD_BITS);
    kind = $urandom_range(0, 19);
    d = vecs(rand_coord(bits), rand_coord(bits), rand_coord(bits),
             rand_coord(bits), rand_coord(bits), rand_coord(bits),
             rand_coord(bits), rand_coord(bits), rand_coord(bits));
    k1 = longint'($urandom_range(0, 6)) - 3;
    k2 = longint'($urandom_range(0, 6)) - 3;
    case (kind)
      0: begin  // a parallel to the bond: first normal vanishes
        d.a_x = coord_t'(k1 * d.b_x);
        d.a_y = coord_t'(k1 * d.b_y);
        d.a_z = coord_t'(k1 * d.b_z);
      end
      1: begin  // c parallel to the bond
        d.c_x = coord_t'(k2 * d.b_x);
        d.c_y = coord_t'(k2 * d.b_y);
        d.c_z = coord_t'(k2 * d.b_z);
      end
      2, 3: begin  // coplanar vectors: cis or trans with a zero sign term
        d.c_x = coord_t'(k1 * d.a_x + k2 * d.b_x);
        d.c_y = coord_t'(k1 * d.a_y + k2 * d.b_y);
        d.c_z = coord_t'(k1 * d.a_z + k2 * d.b_z);
      end
      4, 5: begin
        for (int i = 0; i < 9; i++) d[i*COORD_BITS +: COORD_BITS] = coord_t'($urandom);
      end
      default: ;
    endcase
    return d;
  endfunction

  initial begin
    longint mx, mn;
    da_in_t d;
    mx = 8388607;
    mn = -8388608;
    items.valid = 1'b0;
    items.data = '0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // Directed: zero vectors, extremes, right angles, cis, trans and planar.
    send_item(vecs(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(vecs(1024, 0, 0, 2048, 0, 0, 0, 1024, 0));
    send_item(vecs(0, 1024, 0, 1024, 0, 0, 3072, 0, 0));
    send_item(vecs(0, 1024, 0, 1024, 0, 0, 0, 1024, 0));
    send_item(vecs(0, 1024, 0, 1024, 0, 0, 0, -1024, 0));
    send_item(vecs(0, 1024, 0, 1024, 0, 0, 0, 0, 1024));
    send_item(vecs(0, 1024, 0, 1024, 0, 0, 0, 0, -1024));
    send_item(vecs(0, 1024, 0, 1024, 0, 0, 0, 1024, 1));
    send_item(vecs(0, 1024, 0, 1024, 0, 0, 0, -1024, 1));
    send_item(vecs(0, 1024, 0, 1024, 0, 0, 0, -1024, -1));
    send_item(vecs(mx, mx, mx, mn, mn, mn, mx, mn, mx));
    send_item(vecs(mn, 0, 0, 0, mn, 0, 0, 0, mn));
    send_item(vecs(mx, 0, 0, 0, mx, 0, 0, 0, mx));
    send_item(vecs(mn, mx, 0, 0, 0, mx, mx, mn, 0));
    send_item(vecs(mn, mn, mx, mx, mn, mn, mn, mx, mx));
    send_item(vecs(1, 0, 0, 0, 1, 0, 0, 0, 1));
    send_item(vecs(1, 0, 0, 0, 1, 0, 0, 0, -1));
    send_item(vecs(-1, -1, -1, -1, -1, -1, 1, 1, 1));
    send_item(vecs(mx, mn, 1, -1, mx, mn, 1, mn, mx));
    send_item(vecs(3, 5, 7, -2, 4, -6, 9, -8, 1));
    send_item(vecs(0, 1024, 0, 1024, 0, 0, 1, 1024, 0));

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - QUIET_TAIL) quiet = 1'b1;
      d = random_item();
      send_item(d);
    end
    items.valid = 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    $display("Checked %0d results from %0d requests, %0d degenerate, with stalls",
             board.checked, accepted, board.degen_seen);
    $display("on both sides and one long result hold-off.");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

FILE: filelist.f
hdl/da_pkg.sv
hdl/da_ifs.sv
hdl/da_front.sv
hdl/da_prep.sv
hdl/da_sqrt.sv
hdl/da_cordic.sv
hdl/dihedral_angle.sv
dv/tb_dihedral_angle.sv
